### src/ktss_pkg.sv
// Shared types, constants and the key lookup table for the key-to-scancode sequencer.
package ktss_pkg;

  // Input key event
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] key_value;
  } key_item_t;

  // One emitted scancode
  typedef struct packed {
    logic [7:0] sc_value;
    logic       last;
    logic       exit_request;
  } scan_item_t;

  // Step mask bits, emitted lowest first
  localparam int STEP_CTRL_MAKE   = 0;
  localparam int STEP_SHIFT_MAKE  = 1;
  localparam int STEP_KEY_MAKE    = 2;
  localparam int STEP_KEY_BREAK   = 3;
  localparam int STEP_SHIFT_BREAK = 4;
  localparam int STEP_CTRL_BREAK  = 5;
  localparam int STEP_EXIT        = 6;
  localparam int NUM_STEPS        = 7;

  // Classified run handed from front to back
  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;
    logic [6:0]           code;
  } run_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } queue_status_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

  localparam int QUEUE_DEPTH = 2;

  // Request types
  localparam logic [2:0] REQ_BYTE  = 3'd0;
  localparam logic [2:0] REQ_LEFT  = 3'd1;
  localparam logic [2:0] REQ_RIGHT = 3'd2;
  localparam logic [2:0] REQ_UP    = 3'd3;
  localparam logic [2:0] REQ_DOWN  = 3'd4;

  localparam logic [7:0] KEY_ESC       = 8'd27;
  localparam logic [7:0] KEY_BACKQUOTE = 8'h60;

  localparam logic [7:0] SC_LSHIFT = 8'h2a;
  localparam logic [7:0] SC_LCTRL  = 8'h1d;
  localparam logic [6:0] SC_ESCAPE = 7'h01;
  localparam logic [7:0] SC_BREAK  = 8'h80;
  localparam logic [6:0] SC_LEFT   = 7'h4b;
  localparam logic [6:0] SC_RIGHT  = 7'h4d;
  localparam logic [6:0] SC_UP     = 7'h48;
  localparam logic [6:0] SC_DOWN   = 7'h50;

  // Entry: 0 = no key, bit 7 = shift, low 7 bits = make code
  localparam logic [7:0] KEY_TABLE [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0E,
    8'h0E, 8'h0F, 8'h1C, 8'h00, 8'h00, 8'h1C, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h39, 8'h82, 8'hA8, 8'h84, 8'h85, 8'h86, 8'h88, 8'h28,
    8'h8A, 8'h8B, 8'h89, 8'h8D, 8'h33, 8'h0C, 8'h34, 8'h35,
    8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
    8'h09, 8'h0A, 8'hA7, 8'h27, 8'hB3, 8'h0D, 8'hB4, 8'hB5,
    8'h83, 8'h9E, 8'hB0, 8'hAE, 8'hA0, 8'h92, 8'hA1, 8'hA2,
    8'hA3, 8'h97, 8'hA4, 8'hA5, 8'hA6, 8'hB2, 8'hB1, 8'h98,
    8'h99, 8'h90, 8'h93, 8'h9F, 8'h94, 8'h96, 8'hAF, 8'h91,
    8'hAD, 8'h95, 8'hAC, 8'h1A, 8'h2B, 8'h1B, 8'h87, 8'h8C,
    8'h29, 8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22,
    8'h23, 8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18,
    8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11,
    8'h2D, 8'h15, 8'h2C, 8'h9A, 8'hAB, 8'h9B, 8'hA9, 8'h0E
  };

endpackage

### src/ktss_front.sv
// Front end: accepts key items, tracks the escape prefix and classifies each into a run.
module ktss_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 key_valid,
  output logic                 key_stall,
  input  ktss_pkg::key_item_t  key,
  input  logic                 full,
  output logic                 push,
  output ktss_pkg::run_t       run
);

  logic       escape_pending;
  logic       escape_pending_next;
  logic       accept;
  logic       is_byte;
  logic       legal;
  logic [7:0] entry;
  logic       mapped;
  logic [6:0] arrow;

  assign key_stall = full;
  assign accept    = key_valid && !full;
  assign is_byte   = (key.req_type == ktss_pkg::REQ_BYTE);
  assign legal     = (key.req_type <= ktss_pkg::REQ_DOWN);

  // bytes of 0x80 and above are unmapped
  assign entry  = key.key_value[7] ? 8'h00 : ktss_pkg::KEY_TABLE[key.key_value[6:0]];
  assign mapped = (entry != 8'h00);

  always_comb begin
    unique case (key.req_type)
      ktss_pkg::REQ_LEFT:  arrow = ktss_pkg::SC_LEFT;
      ktss_pkg::REQ_RIGHT: arrow = ktss_pkg::SC_RIGHT;
      ktss_pkg::REQ_UP:    arrow = ktss_pkg::SC_UP;
      ktss_pkg::REQ_DOWN:  arrow = ktss_pkg::SC_DOWN;
      default:             arrow = ktss_pkg::SC_LEFT;
    endcase
  end

  always_comb begin
    run.steps           = '0;
    run.code            = entry[6:0];
    escape_pending_next = escape_pending;
    if (legal) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (is_byte && key.key_value == ktss_pkg::KEY_BACKQUOTE) begin
          run.steps[ktss_pkg::STEP_EXIT] = 1'b1;
        end else if (is_byte && key.key_value == ktss_pkg::KEY_ESC) begin
          run.steps[ktss_pkg::STEP_KEY_MAKE]  = 1'b1;
          run.steps[ktss_pkg::STEP_KEY_BREAK] = 1'b1;
          run.code = ktss_pkg::SC_ESCAPE;
        end else begin
          run.steps[ktss_pkg::STEP_CTRL_MAKE]  = 1'b1;
          run.steps[ktss_pkg::STEP_CTRL_BREAK] = 1'b1;
          if (is_byte && mapped) begin
            run.steps[ktss_pkg::STEP_KEY_MAKE]    = 1'b1;
            run.steps[ktss_pkg::STEP_KEY_BREAK]   = 1'b1;
            run.steps[ktss_pkg::STEP_SHIFT_MAKE]  = entry[7];
            run.steps[ktss_pkg::STEP_SHIFT_BREAK] = entry[7];
          end
        end
      end else if (is_byte) begin
        if (key.key_value == ktss_pkg::KEY_ESC) begin
          escape_pending_next = 1'b1;
        end else if (mapped) begin
          run.steps[ktss_pkg::STEP_KEY_MAKE]    = 1'b1;
          run.steps[ktss_pkg::STEP_KEY_BREAK]   = 1'b1;
          run.steps[ktss_pkg::STEP_SHIFT_MAKE]  = entry[7];
          run.steps[ktss_pkg::STEP_SHIFT_BREAK] = entry[7];
        end
      end else begin
        run.steps[ktss_pkg::STEP_KEY_MAKE]  = 1'b1;
        run.steps[ktss_pkg::STEP_KEY_BREAK] = 1'b1;
        run.code = arrow;
      end
    end
  end

  // empty runs never enter the queue
  assign push = accept && (run.steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

### src/ktss_queue.sv
// Two-entry run queue between the front end and the sequencer.
module ktss_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  ktss_pkg::run_t            push_run,
  input  logic                      pop,
  output ktss_pkg::run_t            head,
  output ktss_pkg::queue_status_t   status
);

  ktss_pkg::run_t mem [ktss_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign status.count = count;
  assign status.full  = (count == 2'(ktss_pkg::QUEUE_DEPTH));
  assign status.empty = (count == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### src/ktss_back.sv
// Sequencer: walks step masks; emits one scancode per unstalled cycle into an output register.
module ktss_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  ktss_pkg::run_t           q_head,
  output logic                     pop,
  output logic                     scan_valid,
  input  logic                     scan_stall,
  output ktss_pkg::scan_item_t     scan,
  output ktss_pkg::back_status_t   status
);

  logic [ktss_pkg::NUM_STEPS-1:0] steps;
  logic [ktss_pkg::NUM_STEPS-1:0] steps_after;
  logic [ktss_pkg::NUM_STEPS-1:0] low;
  logic [ktss_pkg::NUM_STEPS-1:0] rest;
  logic [6:0]                     code;
  logic                           can_adv;
  logic                           emit;
  ktss_pkg::scan_item_t           item;

  assign can_adv     = !scan_valid || !scan_stall;
  assign emit        = can_adv && (steps != '0);
  assign low         = steps & (-steps);
  assign rest        = steps & ~low;
  assign steps_after = emit ? rest : steps;
  assign pop         = q_valid && (steps_after == '0);
  assign status.busy = (steps != '0);

  always_comb begin
    item.last         = (rest == '0);
    item.exit_request = 1'b0;
    case (1'b1)
      low[ktss_pkg::STEP_CTRL_MAKE]:   item.sc_value = ktss_pkg::SC_LCTRL;
      low[ktss_pkg::STEP_SHIFT_MAKE]:  item.sc_value = ktss_pkg::SC_LSHIFT;
      low[ktss_pkg::STEP_KEY_MAKE]:    item.sc_value = {1'b0, code};
      low[ktss_pkg::STEP_KEY_BREAK]:   item.sc_value = {1'b1, code};
      low[ktss_pkg::STEP_SHIFT_BREAK]: item.sc_value = ktss_pkg::SC_LSHIFT | ktss_pkg::SC_BREAK;
      low[ktss_pkg::STEP_CTRL_BREAK]:  item.sc_value = ktss_pkg::SC_LCTRL | ktss_pkg::SC_BREAK;
      low[ktss_pkg::STEP_EXIT]: begin
        item.sc_value     = 8'h00;
        item.exit_request = 1'b1;
      end
      default:                         item.sc_value = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else begin
      steps <= pop ? q_head.steps : steps_after;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code <= q_head.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (can_adv) begin
      scan_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      scan <= item;
    end
  end

endmodule

### src/key_to_scancode_sequencer_core.sv
// Top level of the key-to-scancode sequencer: front end, run queue and sequencer.
// Converts terminal key events (byte keys and arrow keys) into PC set-1 make/break
// scancode runs. An ESC byte gives nothing by itself and modifies the next key:
// backquote then yields a single item with exit_request set, a second ESC yields
// 0x01/0x81, anything else is wrapped in left-ctrl make/break. Shifted characters are
// wrapped in left-shift make/break. Each key item produces 0 to 6 scancode items, one
// per cycle while the output is not stalled, with last marking the final one of a run.
// The front end takes one key item per cycle whenever the two-entry run queue has room;
// the sequencer drains a run at one scancode per cycle while the output is not stalled,
// so sustained throughput is set by the run length. Key items that produce nothing
// (lone ESC, unmapped bytes, undefined request types) never enter the queue. Output
// comes from a register; key_stall is high only while the queue is full.
module key_to_scancode_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  key_valid,
  output logic                  key_stall,
  input  ktss_pkg::key_item_t   key,
  output logic                  scan_valid,
  input  logic                  scan_stall,
  output ktss_pkg::scan_item_t  scan
);

  logic                    push;
  logic                    pop;
  ktss_pkg::run_t          push_run;
  ktss_pkg::run_t          head;
  ktss_pkg::queue_status_t q_status;
  ktss_pkg::back_status_t  b_status;

  // front end: escape tracking and classification
  ktss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key       (key),
    .full      (q_status.full),
    .push      (push),
    .run       (push_run)
  );

  // decouples key acceptance from scancode drain
  ktss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // sequencer: one scancode per cycle unless the output stalls
  ktss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!q_status.empty),
    .q_head     (head),
    .pop        (pop),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .scan       (scan),
    .status     (b_status)
  );

  // exit item is always alone: zero code and closes its run
  a_exit_alone: assert property (@(posedge clk) disable iff (rst)
    scan_valid && scan.exit_request |-> scan.last && scan.sc_value == 8'h00)
    else $error("exit item not a lone final item");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= 2'(ktss_pkg::QUEUE_DEPTH))
    else $error("run queue overflow");

  // an idle sequencer picks up a waiting run on the next cycle
  a_pickup: assert property (@(posedge clk) disable iff (rst)
    !b_status.busy && !q_status.empty |=> b_status.busy)
    else $error("sequencer failed to load queued run");

  // stall toward the source only when the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    key_stall |-> q_status.count == 2'(ktss_pkg::QUEUE_DEPTH))
    else $error("key stall without full queue");

endmodule
